>>> src/atcb_pkg.sv
package atcb_pkg;

  // Field widths
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned SLOT_W  = 2;
  localparam int unsigned NSLOTS  = 4;
  localparam int unsigned CFG_W   = 4;
  localparam int unsigned CFG_IW  = 2;

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_PRESENT  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_LBA_CAP  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_CHANNEL  = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_DRIVE    = 2'd3;

  // Addressing limits and CHS geometry
  localparam logic [ADDR_W-1:0] LBA48_LIMIT = 32'h1000_0000;
  localparam logic [6:0]        CHS_SPT     = 7'd63;

  // Divide by sectors-per-track: remainder by folding 6-bit
  // digits (64 = 1 mod 63), then the exact quotient's low bits by multiplying
  // (lba - remainder) with the inverse of 63 modulo 2^20
  localparam int unsigned       CHS_QW    = 20;
  localparam logic [CHS_QW-1:0] CHS_INV   = 20'hBEFBF;
  localparam int unsigned       DIV_STEPS = 2;
  localparam int unsigned       DIV_CW    = $clog2(DIV_STEPS);

  // Device select bases and commands
  localparam logic [7:0] DEVSEL_LBA  = 8'hE0;
  localparam logic [7:0] DEVSEL_CHS  = 8'hA0;
  localparam logic [7:0] CMD_RD      = 8'h20;
  localparam logic [7:0] CMD_RD_EXT  = 8'h24;
  localparam logic [7:0] CMD_WR      = 8'h30;
  localparam logic [7:0] CMD_WR_EXT  = 8'h34;

  // Task-file register indexes
  localparam logic [3:0] REG_NONE   = 4'd0;
  localparam logic [3:0] REG_COUNT0 = 4'd2;
  localparam logic [3:0] REG_LBA0   = 4'd3;
  localparam logic [3:0] REG_LBA1   = 4'd4;
  localparam logic [3:0] REG_LBA2   = 4'd5;
  localparam logic [3:0] REG_DEVSEL = 4'd6;
  localparam logic [3:0] REG_CMD    = 4'd7;
  localparam logic [3:0] REG_COUNT1 = 4'd8;
  localparam logic [3:0] REG_LBA3   = 4'd9;
  localparam logic [3:0] REG_LBA4   = 4'd10;
  localparam logic [3:0] REG_LBA5   = 4'd11;

  // Queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic [1:0] {
    MODE_ABSENT,
    MODE_LBA48,
    MODE_LBA28,
    MODE_CHS
  } mode_t;

  // One classified request, ready for the sequencer
  typedef struct packed {
    mode_t      mode;
    logic       ch;
    logic [7:0] devsel;
    logic [7:0] cnt0;
    logic [7:0] lba0;
    logic [7:0] lba1;
    logic [7:0] lba2;
    logic [7:0] lba3;
    logic [7:0] cmd;
  } rec_t;

  typedef enum logic [1:0] {
    FS_EMPTY,
    FS_DIV,
    FS_READY
  } fstate_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEVSEL,
    ST_CNT1,
    ST_LBA3,
    ST_LBA4,
    ST_LBA5,
    ST_CNT0,
    ST_LBA0,
    ST_LBA1,
    ST_LBA2,
    ST_CMD
  } bstate_t;

endpackage

>>> src/atcb_front.sv
module atcb_front
  import atcb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [SLOT_W-1:0]   in_drive_slot,
  input  logic                in_is_write,
  input  logic [ADDR_W-1:0]   in_block_address,
  input  logic [7:0]          in_sector_count,
  input  logic                cfg_we,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                q_full,
  output logic                q_push,
  output rec_t                q_rec
);

  fstate_t             fst_r, fst_nxt;
  logic [CFG_W-1:0]    present_r, lba_cap_r, chan_map_r, drv_map_r;
  mode_t               mode_r;
  logic                ch_r, drv_r, wr_r;
  logic [7:0]          cnt_r;
  logic [ADDR_W-1:0]   dv_r;
  logic [5:0]          rem_r, rem_nxt;
  logic [CHS_QW-1:0]   quo_r, quo_nxt;
  logic [CHS_QW-1:0]   trk_base;
  logic [8:0]          dig_sum;
  logic [6:0]          dig_fold;
  logic [DIV_CW-1:0]   step_r;
  logic                accept;
  mode_t               mode_in;
  logic                div_done;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r  <= '0;
      lba_cap_r  <= '0;
      chan_map_r <= '0;
      drv_map_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRESENT: present_r  <= cfg_data;
        CFG_LBA_CAP: lba_cap_r  <= cfg_data;
        CFG_CHANNEL: chan_map_r <= cfg_data;
        CFG_DRIVE:   drv_map_r  <= cfg_data;
      endcase
    end
  end

  // Classify the incoming item
  always_comb begin
    priority if (!present_r[in_drive_slot])       mode_in = MODE_ABSENT;
    else if (in_block_address >= LBA48_LIMIT)     mode_in = MODE_LBA48;
    else if (lba_cap_r[in_drive_slot])            mode_in = MODE_LBA28;
    else                                          mode_in = MODE_CHS;
  end

  // Handshake: a new item may enter in the cycle the held one leaves
  assign q_push   = (fst_r == FS_READY) && !q_full;
  assign busy     = (fst_r != FS_EMPTY) && !q_push;
  assign accept   = start && !busy;
  assign div_done = (fst_r == FS_DIV) && (step_r == DIV_CW'(DIV_STEPS - 1));

  // Remainder by 63: sum the 6-bit digits of the 28-bit address, fold once
  always_comb begin
    dig_sum  = 9'(dv_r[5:0]) + 9'(dv_r[11:6]) + 9'(dv_r[17:12]) + 9'(dv_r[23:18])
             + 9'(dv_r[27:24]);
    dig_fold = 7'(dig_sum[5:0]) + 7'(dig_sum[8:6]);
    rem_nxt  = (dig_fold >= CHS_SPT) ? 6'(dig_fold - CHS_SPT) : dig_fold[5:0];
  end

  // Exact quotient low bits: (lba - rem) times the inverse of 63
  assign trk_base = dv_r[CHS_QW-1:0] - CHS_QW'(rem_r);
  assign quo_nxt  = trk_base * CHS_INV;

  // Front state
  always_comb begin
    fst_nxt = fst_r;
    if (div_done) fst_nxt = FS_READY;
    if (q_push)   fst_nxt = FS_EMPTY;
    if (accept)   fst_nxt = (mode_in == MODE_CHS) ? FS_DIV : FS_READY;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fst_r <= FS_EMPTY;
    end else begin
      fst_r <= fst_nxt;
    end
  end

  // Held item and divider datapath; remainder settles first, quotient second
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= mode_in;
      ch_r   <= chan_map_r[in_drive_slot];
      drv_r  <= drv_map_r[in_drive_slot];
      wr_r   <= in_is_write;
      cnt_r  <= in_sector_count;
      dv_r   <= in_block_address;
      rem_r  <= '0;
      step_r <= '0;
    end else if (fst_r == FS_DIV) begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      step_r <= step_r + 1'b1;
    end
  end

  // Build the register bytes for the queue
  always_comb begin
    q_rec      = '0;
    q_rec.mode = mode_r;
    q_rec.ch   = ch_r;
    q_rec.cnt0 = cnt_r;
    q_rec.lba3 = dv_r[31:24];
    q_rec.cmd  = wr_r ? CMD_WR : CMD_RD;
    unique case (mode_r)
      MODE_ABSENT: begin
        q_rec.cmd = '0;
      end
      MODE_LBA48: begin
        q_rec.devsel = DEVSEL_LBA | {3'b000, drv_r, 4'h0};
        q_rec.lba0   = dv_r[7:0];
        q_rec.lba1   = dv_r[15:8];
        q_rec.lba2   = dv_r[23:16];
        q_rec.cmd    = wr_r ? CMD_WR_EXT : CMD_RD_EXT;
      end
      MODE_LBA28: begin
        q_rec.devsel = DEVSEL_LBA | {3'b000, drv_r, dv_r[27:24]};
        q_rec.lba0   = dv_r[7:0];
        q_rec.lba1   = dv_r[15:8];
        q_rec.lba2   = dv_r[23:16];
      end
      MODE_CHS: begin
        // quotient in quo_r: head = q[3:0], cylinder = q[19:4]
        q_rec.devsel = DEVSEL_CHS | {3'b000, drv_r, quo_r[3:0]};
        q_rec.lba0   = {2'b00, rem_r} + 8'd1;
        q_rec.lba1   = quo_r[11:4];
        q_rec.lba2   = quo_r[19:12];
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (fst_r == FS_DIV) || (fst_r == FS_READY))
    else $error("front lost an accepted item");

  assert property (@(posedge clk) disable iff (!rst_n)
    (fst_r == FS_DIV) |-> busy)
    else $error("front took an item while dividing");

  assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("push into a full queue");

endmodule

>>> src/atcb_queue.sv
module atcb_queue
  import atcb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rec_t push_rec,
  input  logic pop,
  output rec_t head,
  output logic full,
  output logic empty
);

  rec_t              ent_r [Q_DEPTH];
  logic [Q_AW-1:0]   wp_r, rp_r;
  logic [Q_AW:0]     cnt_r;

  assign full  = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = ent_r[rp_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_rec;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (Q_AW+1)'(Q_DEPTH))
    else $error("queue count overflow");

  assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from an empty queue");

  assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> !empty)
    else $error("pushed item vanished");

endmodule

>>> src/atcb_back.sv
module atcb_back
  import atcb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  rec_t       q_head,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_valid,
  output logic       out_channel_sel,
  output logic [3:0] out_reg_index,
  output logic [7:0] out_reg_value,
  output logic       out_not_present,
  output logic       out_last
);

  bstate_t    st_r, st_nxt;
  rec_t       cur_r;
  logic       fin;
  logic       absent;
  logic [3:0] idx;
  logic [7:0] val;
  logic       out_valid_r, out_ch_r, out_np_r, out_last_r;
  logic [3:0] out_idx_r;
  logic [7:0] out_val_r;

  assign absent = (cur_r.mode == MODE_ABSENT);
  assign fin    = (st_r == ST_CMD) || ((st_r == ST_DEVSEL) && absent);
  assign q_pop  = ((st_r == ST_IDLE) || fin) && !q_empty;

  // Sequencer: next write and its register/byte
  always_comb begin
    st_nxt = st_r;
    idx    = REG_NONE;
    val    = '0;
    unique case (st_r)
      ST_IDLE: begin
        st_nxt = ST_IDLE;
      end
      ST_DEVSEL: begin
        idx    = REG_DEVSEL;
        val    = cur_r.devsel;
        st_nxt = (cur_r.mode == MODE_LBA48) ? ST_CNT1 : ST_CNT0;
      end
      ST_CNT1: begin idx = REG_COUNT1; val = '0;          st_nxt = ST_LBA3; end
      ST_LBA3: begin idx = REG_LBA3;   val = cur_r.lba3;  st_nxt = ST_LBA4; end
      ST_LBA4: begin idx = REG_LBA4;   val = '0;          st_nxt = ST_LBA5; end
      ST_LBA5: begin idx = REG_LBA5;   val = '0;          st_nxt = ST_CNT0; end
      ST_CNT0: begin idx = REG_COUNT0; val = cur_r.cnt0;  st_nxt = ST_LBA0; end
      ST_LBA0: begin idx = REG_LBA0;   val = cur_r.lba0;  st_nxt = ST_LBA1; end
      ST_LBA1: begin idx = REG_LBA1;   val = cur_r.lba1;  st_nxt = ST_LBA2; end
      ST_LBA2: begin idx = REG_LBA2;   val = cur_r.lba2;  st_nxt = ST_CMD;  end
      ST_CMD:  begin idx = REG_CMD;    val = cur_r.cmd;   st_nxt = ST_IDLE; end
      default: begin st_nxt = ST_IDLE; end
    endcase
    // absent slot: one error result, no writes
    if (absent) begin
      idx = REG_NONE;
      val = '0;
    end
    if (fin)   st_nxt = ST_IDLE;
    if (q_pop) st_nxt = ST_DEVSEL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= (st_r != ST_IDLE);
    end
  end

  // Current item and output register
  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_head;
    out_ch_r   <= absent ? 1'b0 : cur_r.ch;
    out_idx_r  <= idx;
    out_val_r  <= val;
    out_np_r   <= absent && (st_r != ST_IDLE);
    out_last_r <= fin;
  end

  assign out_valid       = out_valid_r;
  assign out_channel_sel = out_ch_r;
  assign out_reg_index   = out_idx_r;
  assign out_reg_value   = out_val_r;
  assign out_not_present = out_np_r;
  assign out_last        = out_last_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CMD) |=> out_valid_r && out_last_r)
    else $error("command write not marked last");

  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) |=> !out_valid_r)
    else $error("result strobe while idle");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_np_r) |-> out_last_r)
    else $error("error result not final");

endmodule

>>> src/ata_taskfile_command_builder.sv
// Channel  Handshake            Ports
// -------  -------------------  ----------------------------------------------
// input    start & !busy        in_drive_slot in_is_write in_block_address
//                               in_sector_count
// result   out_valid, 1 cycle   out_channel_sel out_reg_index out_reg_value
//                               out_not_present out_last
// config   cfg_we               cfg_index cfg_data
//
// An item yields 1 result (absent slot), 6 (LBA28/CHS) or 10 (LBA48), one per
// cycle from the back sequencer, which sets the pace of a stream of items.
// CHS items pass the front divide-by-63 unit (digit-fold remainder, then
// inverse multiply) before the queue and the back sequencer.
// A two-entry queue separates front and back; busy is high while the divider
// runs or while a held item waits on a full queue. Reset (rst_n low,
// synchronous) clears config, queue and states; the receiver cannot stall.
module ata_taskfile_command_builder
  import atcb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [SLOT_W-1:0]   in_drive_slot,
  input  logic                in_is_write,
  input  logic [ADDR_W-1:0]   in_block_address,
  input  logic [7:0]          in_sector_count,
  input  logic                cfg_we,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  output logic                out_valid,
  output logic                out_channel_sel,
  output logic [3:0]          out_reg_index,
  output logic [7:0]          out_reg_value,
  output logic                out_not_present,
  output logic                out_last
);

  rec_t push_rec, head_rec;
  logic q_push, q_pop, q_full, q_empty;

  // Accept and classify
  atcb_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_drive_slot    (in_drive_slot),
    .in_is_write      (in_is_write),
    .in_block_address (in_block_address),
    .in_sector_count  (in_sector_count),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_rec            (push_rec)
  );

  // Item queue
  atcb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (push_rec),
    .pop      (q_pop),
    .head     (head_rec),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Register-write sequencer
  atcb_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_head          (head_rec),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_channel_sel (out_channel_sel),
    .out_reg_index   (out_reg_index),
    .out_reg_value   (out_reg_value),
    .out_not_present (out_not_present),
    .out_last        (out_last)
  );

endmodule
